// File: hw/rtl/por_pkg.sv
`default_nettype none
package por_pkg;
  localparam int COORD_BITS_DEF = 6;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [5:0] vertex_x;
    logic [5:0] vertex_y;
    logic       begin_figure;
  } vertex_t;

  typedef struct packed {
    logic [5:0] pixel_x;
    logic [5:0] pixel_y;
    logic       closing_edge;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic edge_done;
  } dp_status_t;
endpackage
`default_nettype wire

// File: hw/rtl/por_datapath.sv
`default_nettype none
module por_datapath #(
  parameter int COORD_BITS = por_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = por_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                bres,
  input  wire logic [COORD_BITS-1:0] xb_in,
  input  wire logic [COORD_BITS-1:0] yb_in,
  input  wire logic [COORD_BITS-1:0] xe_in,
  input  wire logic [COORD_BITS-1:0] ye_in,
  input  wire por_pkg::dp_cmd_t    cmd,
  output por_pkg::dp_status_t      status,
  output logic [COORD_BITS-1:0]    px,
  output logic [COORD_BITS-1:0]    py
);
  import por_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int QW = CB + FRAC_BITS;
  localparam int AW = QW + 2;
  localparam int DW = CB + 3;
  localparam int NW = CB + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic signed [CB:0] xb, yb, xe, ye, dx, dy, adx, ady;
  logic xmaj;
  logic [CB-1:0] amaj, amin;
  logic min_neg, maj_neg;
  logic [NW-1:0] quo;
  logic [CB:0] rem;
  logic [CW-1:0] dcnt;
  logic [CB:0] trial;
  logic signed [AW-1:0] acc, slope, accr;
  logic signed [DW-1:0] term, inc_s, inc_n;
  logic [CB-1:0] cnt, maj, mino;
  logic swap;
  logic [CB-1:0] sxb, syb;

  always_comb begin
    xb = {1'b0, xb_in};
    yb = {1'b0, yb_in};
    xe = {1'b0, xe_in};
    ye = {1'b0, ye_in};
    dx = xe - xb;
    dy = ye - yb;
    adx = dx[CB] ? -dx : dx;
    ady = dy[CB] ? -dy : dy;
    xmaj = adx > ady;
    amaj = xmaj ? adx[CB-1:0] : ady[CB-1:0];
    amin = xmaj ? ady[CB-1:0] : adx[CB-1:0];
    maj_neg = xmaj ? dx[CB] : dy[CB];
    min_neg = xmaj ? dy[CB] : dx[CB];
    swap = xmaj ? (xb >= xe) : (yb >= ye);
    sxb = swap ? xe_in : xb_in;
    syb = swap ? ye_in : yb_in;
    trial = {rem[CB-1:0], quo[NW-1]} - {1'b0, amaj};
    accr = acc + (AW'(1) <<< (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= NW'(amin) << FRAC_BITS;
      rem <= '0;
      dcnt <= CW'(NW);
    end else if (cmd.div_step) begin
      if (!trial[CB]) begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[CB-1:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.setup) begin
      cnt <= amaj;
      if (bres) begin
        maj <= xmaj ? sxb : syb;
        mino <= xmaj ? syb : sxb;
        if (maj_neg ^ min_neg) begin
          term <= DW'(-2 * $signed({1'b0, amin})) + DW'($signed({1'b0, amaj}));
          inc_s <= DW'(-2 * $signed({1'b0, amin})) + DW'(2 * $signed({1'b0, amaj}));
          inc_n <= DW'(-2 * $signed({1'b0, amin}));
        end else begin
          term <= DW'(2 * $signed({1'b0, amin})) - DW'($signed({1'b0, amaj}));
          inc_s <= DW'(2 * $signed({1'b0, amin})) - DW'(2 * $signed({1'b0, amaj}));
          inc_n <= DW'(2 * $signed({1'b0, amin}));
        end
      end else begin
        maj <= xmaj ? xb_in : yb_in;
        acc <= AW'({1'b0, xmaj ? yb_in : xb_in}) <<< FRAC_BITS;
        slope <= (amaj == '0) ? '0 :
                 (min_neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));
      end
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
      if (bres) begin
        maj <= maj + 1'b1;
        if ((maj_neg ^ min_neg) ? (term <= 0) : (term >= 0)) begin
          mino <= (maj_neg ^ min_neg) ? mino - 1'b1 : mino + 1'b1;
          term <= term + inc_s;
        end else begin
          term <= term + inc_n;
        end
      end else begin
        maj <= maj_neg ? maj - 1'b1 : maj + 1'b1;
        acc <= acc + slope;
      end
    end
  end

  logic [CB-1:0] dmin;
  assign dmin = accr[AW-1] ? '0 : accr[FRAC_BITS +: CB];
  assign px = bres ? (xmaj ? maj : mino) : (xmaj ? maj : dmin);
  assign py = bres ? (xmaj ? mino : maj) : (xmaj ? dmin : maj);
  assign status.div_done = (dcnt == '0);
  assign status.edge_done = (cnt == '0);
endmodule
`default_nettype wire

// File: hw/rtl/por_ctrl.sv
`default_nettype none
module por_ctrl #(
  parameter int COORD_BITS = por_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire por_pkg::vertex_t      in_req,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       closing,
  output logic [COORD_BITS-1:0]      xb,
  output logic [COORD_BITS-1:0]      yb,
  output logic [COORD_BITS-1:0]      xe,
  output logic [COORD_BITS-1:0]      ye,
  output por_pkg::dp_cmd_t           cmd,
  input  wire por_pkg::dp_status_t   status
);
  import por_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_DIV = 6'b000100,
    S_SETUP = 6'b001000, S_RUN = 6'b010000, S_HOLD = 6'b100000
  } state_t;
  state_t state, state_next;
  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, vx, vy;
  logic figure_open, acc_in, is_close;

  assign vx = in_req.vertex_x[COORD_BITS-1:0];
  assign vy = in_req.vertex_y[COORD_BITS-1:0];
  assign in_ready = (state == S_IDLE);
  assign acc_in = in_valid && in_ready;
  assign is_close = (vx == prev_x) && (vy == prev_y);
  assign out_valid = (state == S_RUN);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (acc_in && !in_req.begin_figure && figure_open) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = !status.div_done;
        if (status.div_done) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (out_ready) begin
          cmd.step = 1'b1;
          if (status.edge_done) state_next = S_HOLD;
        end
      end
      S_HOLD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      figure_open <= 1'b0;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      state <= state_next;
      if (acc_in) begin
        if (in_req.begin_figure) begin
          first_x <= vx;
          first_y <= vy;
          prev_x <= vx;
          prev_y <= vy;
          figure_open <= 1'b1;
        end else if (figure_open) begin
          if (is_close) begin
            figure_open <= 1'b0;
          end else begin
            prev_x <= vx;
            prev_y <= vy;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && figure_open && !in_req.begin_figure) begin
      closing <= is_close;
      xb <= is_close ? first_x : prev_x;
      yb <= is_close ? first_y : prev_y;
      xe <= vx;
      ye <= vy;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/polygon_outline_rasterizer.sv
// The first pixel of an edge follows the vertex request through the load, divide and setup
// states (bit-serial slope divider, run in both modes), then one pixel per cycle while out_ready is high.
// Vertices that begin a figure or find no figure open draw nothing.
// One vertex is in flight at a time.
// Reset rst is synchronous and clears the figure state, controller and mode register.
`default_nettype none
module polygon_outline_rasterizer #(
  parameter int COORD_BITS = por_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = por_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire por_pkg::vertex_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output por_pkg::pixel_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata
);
  import por_pkg::*;
  logic line_algorithm, closing;
  logic [COORD_BITS-1:0] xb, yb, xe, ye, px, py;
  dp_cmd_t cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) line_algorithm <= 1'b0;
    else if (cfg_we) line_algorithm <= cfg_wdata;
  end

  por_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk, .rst, .in_req(in_data), .in_valid, .in_ready, .out_valid, .out_ready,
    .closing, .xb, .yb, .xe, .ye, .cmd, .status
  );

  por_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .bres(line_algorithm), .xb_in(xb), .yb_in(yb), .xe_in(xe), .ye_in(ye),
    .cmd, .status, .px, .py
  );

  assign out_data.pixel_x = 6'(px);
  assign out_data.pixel_y = 6'(py);
  assign out_data.closing_edge = closing;
  assign out_data.last_pixel = status.edge_done;
endmodule
`default_nettype wire

// File: hw/rtl/por_checker.sv
`default_nettype none
module por_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire por_pkg::pixel_t  out_data
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while pixels pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pixel request changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_pixel |=> !out_valid)
    else $error("pixels after last pixel");
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_pixel |=> out_valid)
    else $error("edge ended without last pixel");
endmodule
bind polygon_outline_rasterizer por_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
